// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold on every clock edge outside reset.
`define CABT_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define CABT_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/cabt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cabt_pkg;

	localparam int SLOTS_DEF = 64;

	localparam int ADDR_W  = 64;
	localparam int PORT_W  = 16;
	localparam int RIDX_W  = 6;
	localparam int BASE_W  = 32;
	localparam int OIDX_W  = 6;
	localparam int OCNT_W  = 7;
	localparam int IN_DW   = 152;
	localparam int OUT_DW  = 48;

	typedef enum logic {
		OP_LOOKUP  = 1'b0,
		OP_RELEASE = 1'b1
	} cabt_op_t;

	typedef enum logic [2:0] {
		ST_FOUND        = 3'd0,
		ST_ALLOC        = 3'd1,
		ST_FULL         = 3'd2,
		ST_RELEASED     = 3'd3,
		ST_FREE_RELEASE = 3'd4
	} cabt_status_t;

	// controller to datapath
	typedef struct packed {
		logic load;    // latch incoming word
		logic cmp;     // register compare vectors
		logic enc;     // register encoded indices
		logic commit;  // update table, load result register
	} cabt_cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/cabt_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module cabt_ctrl
	import cabt_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  wire logic  out_ready,
	output cabt_cmd_t  cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_ENC,
		S_UPD
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   commit;

	// result register must be empty or emptying before a new result lands
	assign commit = (state_q == S_UPD) && (!out_valid_q || out_ready);

	assign in_ready   = (state_q == S_IDLE);
	assign out_valid  = out_valid_q;
	assign cmd.load   = (state_q == S_IDLE) && in_valid;
	assign cmd.cmp    = (state_q == S_CMP);
	assign cmd.enc    = (state_q == S_ENC);
	assign cmd.commit = commit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					state_q <= S_ENC;
				end
				S_ENC: begin
					state_q <= S_UPD;
				end
				S_UPD: begin
					if (commit) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`CABT_ASSERT_NEXT(a_accept_to_cmp, clk, arst_n, (state_q == S_IDLE) && in_valid, state_q == S_CMP, "accepted word did not start compare")
	`CABT_ASSERT_NEXT(a_upd_holds, clk, arst_n, (state_q == S_UPD) && out_valid_q && !out_ready, (state_q == S_UPD) && out_valid_q, "result overwritten while stalled")

endmodule

`default_nettype wire

// ===== hw/rtl/cabt_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module cabt_datapath
	import cabt_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cabt_cmd_t          cmd,
	input  wire logic               in_opcode,
	input  wire logic [ADDR_W-1:0]  in_addr_high,
	input  wire logic [ADDR_W-1:0]  in_addr_low,
	input  wire logic [PORT_W-1:0]  in_port,
	input  wire logic [RIDX_W-1:0]  in_release_index,
	input  wire logic [BASE_W-1:0]  ipv4_base,
	output cabt_status_t            res_status,
	output logic [OIDX_W-1:0]       res_slot_index,
	output logic [BASE_W-1:0]       res_ipv4_address,
	output logic [OCNT_W-1:0]       res_entry_count,
	output logic                    res_table_full
);

	localparam int IW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);

	// latched word
	logic               op_q;
	logic [ADDR_W-1:0]  kh_q;
	logic [ADDR_W-1:0]  kl_q;
	logic [PORT_W-1:0]  kp_q;
	logic [RIDX_W-1:0]  rel_q;

	// slot cells
	logic [SLOTS-1:0]   valid_q;
	logic [ADDR_W-1:0]  slot_hi_q [SLOTS];
	logic [ADDR_W-1:0]  slot_lo_q [SLOTS];
	logic [PORT_W-1:0]  slot_port_q [SLOTS];
	logic [CW-1:0]      count_q;

	// compare stage
	logic [SLOTS-1:0]   match_s1;
	logic [SLOTS-1:0]   free_s1;
	logic               rel_ok_s1;
	logic [SLOTS-1:0]   match_now;

	// encode stage
	logic               hit_s2;
	logic [IW-1:0]      hit_idx_s2;
	logic               any_free_s2;
	logic [IW-1:0]      free_idx_s2;
	logic               rel_ok_s2;

	// result register
	cabt_status_t       out_status_q;
	logic [OIDX_W-1:0]  out_idx_q;
	logic [BASE_W-1:0]  out_addr_q;
	logic [OCNT_W-1:0]  out_cnt_q;
	logic               out_full_q;

	// release index, widened so the range check works for any table size
	logic [IW+RIDX_W-1:0] rel_ext;
	logic                 rel_in_range;
	logic [IW-1:0]        rel_idx;

	assign rel_ext      = {{IW{1'b0}}, rel_q};
	assign rel_in_range = rel_ext < (IW+RIDX_W)'(SLOTS);
	assign rel_idx      = rel_ext[IW-1:0];

	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			match_now[i] = valid_q[i] && (slot_hi_q[i] == kh_q) &&
				(slot_lo_q[i] == kl_q) && (slot_port_q[i] == kp_q);
		end
	end

	// lowest match and highest free slot: isolate lowest set bit, then OR out index
	logic [SLOTS-1:0] free_rev;
	logic [SLOTS-1:0] match_oh;
	logic [SLOTS-1:0] free_oh;
	logic [IW-1:0]    hit_idx_c;
	logic [IW-1:0]    free_pos_c;
	logic [IW-1:0]    top_idx;

	assign top_idx = IW'(SLOTS - 1);

	always_comb begin
		for (int i = 0; i < SLOTS; i++) begin
			free_rev[i] = free_s1[SLOTS-1-i];
		end
		match_oh   = match_s1 & (~match_s1 + SLOTS'(1));
		free_oh    = free_rev & (~free_rev + SLOTS'(1));
		hit_idx_c  = '0;
		free_pos_c = '0;
		for (int i = 0; i < SLOTS; i++) begin
			if (match_oh[i]) begin
				hit_idx_c = hit_idx_c | IW'(i);
			end
			if (free_oh[i]) begin
				free_pos_c = free_pos_c | IW'(i);
			end
		end
	end

	// update decision
	cabt_status_t      status_c;
	logic [IW-1:0]     sel_idx_c;
	logic [CW-1:0]     count_c;
	logic              alloc_c;
	logic              release_c;
	logic [IW+OIDX_W-1:0] idx_ext;
	logic [CW+OCNT_W-1:0] cnt_ext;
	logic [OIDX_W-1:0] out_idx_c;
	logic [BASE_W-1:0] out_addr_c;

	always_comb begin
		status_c  = ST_FULL;
		sel_idx_c = '0;
		alloc_c   = 1'b0;
		release_c = 1'b0;
		count_c   = count_q;
		if (op_q == OP_RELEASE) begin
			sel_idx_c = rel_idx;
			if (rel_ok_s2) begin
				status_c  = ST_RELEASED;
				release_c = 1'b1;
				if (count_q != '0) begin
					count_c = count_q - CW'(1);
				end
			end else begin
				status_c = ST_FREE_RELEASE;
			end
		end else if (hit_s2) begin
			status_c  = ST_FOUND;
			sel_idx_c = hit_idx_s2;
		end else if (any_free_s2) begin
			status_c  = ST_ALLOC;
			sel_idx_c = free_idx_s2;
			alloc_c   = 1'b1;
			count_c   = count_q + CW'(1);
		end

		idx_ext = {{OIDX_W{1'b0}}, sel_idx_c};
		cnt_ext = {{OCNT_W{1'b0}}, count_c};
		if (op_q == OP_RELEASE) begin
			out_idx_c  = rel_q;
			out_addr_c = ipv4_base + BASE_W'(rel_q);
		end else if (status_c == ST_FULL) begin
			out_idx_c  = '0;
			out_addr_c = '0;
		end else begin
			out_idx_c  = idx_ext[OIDX_W-1:0];
			out_addr_c = ipv4_base + BASE_W'(sel_idx_c);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			count_q  <= '0;
			match_s1 <= '0;
		end else begin
			if (cmd.cmp) begin
				match_s1 <= match_now;
			end
			if (cmd.commit) begin
				count_q <= count_c;
				if (alloc_c) begin
					valid_q[sel_idx_c] <= 1'b1;
				end
				if (release_c) begin
					valid_q[sel_idx_c] <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= in_opcode;
			kh_q  <= in_addr_high;
			kl_q  <= in_addr_low;
			kp_q  <= in_port;
			rel_q <= in_release_index;
		end
		if (cmd.cmp) begin
			free_s1   <= ~valid_q;
			rel_ok_s1 <= rel_in_range && valid_q[rel_idx];
		end
		if (cmd.enc) begin
			hit_s2      <= |match_s1;
			hit_idx_s2  <= hit_idx_c;
			any_free_s2 <= |free_s1;
			free_idx_s2 <= top_idx - free_pos_c;
			rel_ok_s2   <= rel_ok_s1;
		end
		if (cmd.commit) begin
			if (alloc_c) begin
				slot_hi_q[sel_idx_c]   <= kh_q;
				slot_lo_q[sel_idx_c]   <= kl_q;
				slot_port_q[sel_idx_c] <= kp_q;
			end
			out_status_q <= status_c;
			out_idx_q    <= out_idx_c;
			out_addr_q   <= out_addr_c;
			out_cnt_q    <= cnt_ext[OCNT_W-1:0];
			out_full_q   <= (count_c == CW'(SLOTS));
		end
	end

	assign res_status       = out_status_q;
	assign res_slot_index   = out_idx_q;
	assign res_ipv4_address = out_addr_q;
	assign res_entry_count  = out_cnt_q;
	assign res_table_full   = out_full_q;

	`CABT_ASSERT(a_count_matches_valid, clk, arst_n, $countones(valid_q) == int'(count_q), "entry count out of step with valid bits")
	`CABT_ASSERT(a_unique_match, clk, arst_n, $onehot0(match_s1), "key held in more than one slot")

endmodule

`default_nettype wire

// ===== hw/rtl/client_address_binding_table.sv =====
// Client address binding table: lookup-or-allocate over a fixed set of slots.
// Input stream s_axis: tuser carries the opcode (lookup, release), tdata the
// IPv6 key halves, port and release index. One word is taken while the block
// is idle; the key is compared against every slot cell at once.
// Output stream m_axis: tuser carries the status, tdata the slot index, IPv4
// address (base + index), entry count and full flag.
// The result is registered after the compare, encode and update steps that
// follow the taken input word. A new word is taken on the cycle after the
// update, so the block takes no new word while one is still in flight.
// The result sits in an output register; an update waits while it holds a
// result and m_axis_tready is low, and input stays blocked until it frees up.
// cfg_we writes the IPv4 base from cfg_data; write only while idle.
// Reset (arst_n low) frees every slot, clears the count and the base; slot
// contents are left as they are and only read while their slot is valid.
`timescale 1ns / 1ps
`default_nettype none

module client_address_binding_table
	import cabt_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [BASE_W-1:0] cfg_data,
	input  wire logic              s_axis_tvalid,
	output logic                   s_axis_tready,
	// [63:0] key_addr_high, [127:64] key_addr_low, [143:128] key_port,
	// [149:144] release_index, [151:150] zero
	input  wire logic [IN_DW-1:0]  s_axis_tdata,
	// [0] opcode
	input  wire logic [0:0]        s_axis_tuser,
	output logic                   m_axis_tvalid,
	input  wire logic              m_axis_tready,
	// [5:0] slot_index, [37:6] ipv4_address, [44:38] entry_count,
	// [45] table_full, [47:46] zero
	output logic [OUT_DW-1:0]      m_axis_tdata,
	// [2:0] status
	output logic [2:0]             m_axis_tuser
);

	logic [BASE_W-1:0] base_q;
	cabt_cmd_t         cmd;
	cabt_status_t      res_status;
	logic [OIDX_W-1:0] res_slot_index;
	logic [BASE_W-1:0] res_ipv4_address;
	logic [OCNT_W-1:0] res_entry_count;
	logic              res_table_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (cfg_we) begin
			base_q <= cfg_data;
		end
	end

	cabt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd)
	);

	cabt_datapath #(
		.SLOTS (SLOTS)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.in_opcode        (s_axis_tuser[0]),
		.in_addr_high     (s_axis_tdata[63:0]),
		.in_addr_low      (s_axis_tdata[127:64]),
		.in_port          (s_axis_tdata[143:128]),
		.in_release_index (s_axis_tdata[149:144]),
		.ipv4_base        (base_q),
		.res_status       (res_status),
		.res_slot_index   (res_slot_index),
		.res_ipv4_address (res_ipv4_address),
		.res_entry_count  (res_entry_count),
		.res_table_full   (res_table_full)
	);

	assign m_axis_tdata = {2'b00, res_table_full, res_entry_count,
		res_ipv4_address, res_slot_index};
	assign m_axis_tuser = res_status;

endmodule

`default_nettype wire
